[rtl/sdcq_pkg.sv]
// Shared types, constants and codes of the sorted delayed call queue.
`timescale 1ns / 1ps

package sdcq_pkg;

    // Fixed field widths of the transfer payloads.
    localparam int FUNC_W   = 2;
    localparam int TIME_W   = 32;
    localparam int DELAY_W  = 16;
    localparam int TGT_W    = 16;
    localparam int STATUS_W = 2;
    localparam int OUT_ID_W = 16;

    // Most results that one run request may produce.
    localparam int MAX_OUT = 16;

    // Defaults of the top-level parameters.
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF     = 16;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_SCHEDULE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CANCEL   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RUN      = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [TIME_W-1:0]  now_time;
        logic [DELAY_W-1:0] delay;
        logic [TGT_W-1:0]   target_id;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OUT_ID_W-1:0] out_id;
        logic                fired;
        logic                last;
        logic                head_pending;
        logic [TIME_W-1:0]   head_time;
        logic [TIME_W-1:0]   next_delay;
    } t_rsp;

    // Which logical queue position the storage read addresses.
    typedef enum logic [1:0] {
        RD_PREV = 2'd0,
        RD_CUR  = 2'd1,
        RD_NEXT = 2'd2,
        RD_HEAD = 2'd3
    } t_rd_sel;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic    capture;
        logic    set_full;
        logic    set_notfound;
        logic    idx_from_count;
        logic    idx_inc;
        logic    idx_dec;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    wr_rdata;
        logic    wr_new;
        logic    cnt_dec;
        logic    pop;
        logic    head_load;
        logic    emit;
    } t_cmd;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              full;
        logic              empty;
        logic              idx_zero;
        logic              idx_last;
        logic              later;
        logic              tag_hit;
        logic              expired;
        logic              exp_full;
        logic              out_free;
        logic              emit_last;
    } t_stat;

endpackage

[rtl/sdcq_chan_if.sv]
// Valid/ready channel interface carrying one payload per transfer.
`timescale 1ns / 1ps

interface sdcq_chan_if #(
    parameter type T_PAYLOAD = logic
) ();
    logic     valid;
    logic     ready;
    T_PAYLOAD payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/sorted_delayed_call_queue_unit.sv]
// Top level of the sorted delayed call queue: sequencer plus datapath behind two channels.
`timescale 1ns / 1ps

// The block keeps up to QUEUE_DEPTH timed entries in order of due time, ties in
// order of arrival, in a single circular RAM with one write and one registered
// read port. A request is a schedule (adds an entry due at now_time + delay,
// saturating at the largest time, and returns a fresh nonzero id), a cancel
// (removes the entry nearest the head that carries target_id, or answers
// id not found) or a run (pops every entry due at or before now_time, at most
// sixteen per request, one result per expired id, the last one marked; with
// nothing expired a single result with fired clear). Code 3 changes nothing and
// answers one plain result. Every result reports the head due time and the
// remaining delay as they stand after the whole request. Requests are handled
// one at a time; the rate is set by the single RAM read port, whose registered
// data must be awaited on every entry visited. A schedule moves each queued entry
// due later than the new one down a row, from the tail, and then writes the new
// entry. A cancel reads from the head until it finds target_id or has read the
// last entry, and on a hit moves every entry behind the removed one up a row. A
// run pops entries from the head until one is not yet due, the queue is empty
// or sixteen are taken, and then sends one result per popped entry. A schedule,
// a cancel that hits and a run end with a read of the new head due time; a full
// queue, an empty queue on cancel and code 3 leave the storage untouched. Each
// result waits while the output register is still held by the receiver.
// Results leave through an output register, so the block takes the next
// request while the final result of the previous one still awaits its transfer.
// No initialisation pass is needed after reset.
module sorted_delayed_call_queue_unit #(
    parameter int QUEUE_DEPTH = sdcq_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = sdcq_pkg::ID_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sdcq_chan_if.sink   i_req,
    sdcq_chan_if.source o_rsp
);
    import sdcq_pkg::*;

    t_cmd w_cmd;
    t_stat w_stat;
    logic w_in_ready;
    logic w_out_valid;
    t_rsp w_rsp;

    // The sequencer walks each request through its storage passes.
    sdcq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the entries, the cursors and the result register.
    sdcq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_req_data  (i_req.payload),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (w_out_valid),
        .o_rsp_data  (w_rsp)
    );

    assign i_req.ready   = w_in_ready;
    assign o_rsp.valid   = w_out_valid;
    assign o_rsp.payload = w_rsp;
endmodule

[rtl/sdcq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module sdcq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/sdcq_ctrl.sv]
// Sequencer of the sorted delayed call queue: one-hot state machine issuing datapath commands.
`timescale 1ns / 1ps

module sdcq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  sdcq_pkg::t_stat i_stat,
    output sdcq_pkg::t_cmd  o_cmd
);
    import sdcq_pkg::*;

    typedef enum logic [16:0] {
        S_IDLE     = 17'h00001,
        S_DISPATCH = 17'h00002,
        S_INS_CHK  = 17'h00004,
        S_INS_RD   = 17'h00008,
        S_INS_CMP  = 17'h00010,
        S_INS_WR   = 17'h00020,
        S_CAN_RD   = 17'h00040,
        S_CAN_CMP  = 17'h00080,
        S_SHF_CHK  = 17'h00100,
        S_SHF_RD   = 17'h00200,
        S_SHF_WR   = 17'h00400,
        S_RUN_CHK  = 17'h00800,
        S_RUN_RD   = 17'h01000,
        S_RUN_CMP  = 17'h02000,
        S_HEAD_RD  = 17'h04000,
        S_HEAD_LD  = 17'h08000,
        S_EMIT     = 17'h10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                priority if (i_stat.func == FUNC_SCHEDULE) begin
                    if (i_stat.full) begin
                        o_cmd.set_full = 1'b1;
                        n_state        = S_EMIT;
                    end else begin
                        o_cmd.idx_from_count = 1'b1;
                        n_state              = S_INS_CHK;
                    end
                end else if (i_stat.func == FUNC_CANCEL) begin
                    if (i_stat.empty) begin
                        o_cmd.set_notfound = 1'b1;
                        n_state            = S_EMIT;
                    end else begin
                        n_state = S_CAN_RD;
                    end
                end else if (i_stat.func == FUNC_RUN) begin
                    n_state = S_RUN_CHK;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_INS_CHK: begin
                n_state = i_stat.idx_zero ? S_INS_WR : S_INS_RD;
            end
            S_INS_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_PREV;
                n_state      = S_INS_CMP;
            end
            S_INS_CMP: begin
                if (i_stat.later) begin
                    o_cmd.wr_rdata = 1'b1;
                    o_cmd.idx_dec  = 1'b1;
                    n_state        = S_INS_CHK;
                end else begin
                    n_state = S_INS_WR;
                end
            end
            S_INS_WR: begin
                o_cmd.wr_new = 1'b1;
                n_state      = S_HEAD_RD;
            end
            S_CAN_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_CUR;
                n_state      = S_CAN_CMP;
            end
            S_CAN_CMP: begin
                priority if (i_stat.tag_hit) begin
                    n_state = S_SHF_CHK;
                end else if (i_stat.idx_last) begin
                    o_cmd.set_notfound = 1'b1;
                    n_state            = S_EMIT;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_CAN_RD;
                end
            end
            S_SHF_CHK: begin
                if (i_stat.idx_last) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_HEAD_RD;
                end else begin
                    n_state = S_SHF_RD;
                end
            end
            S_SHF_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_NEXT;
                n_state      = S_SHF_WR;
            end
            S_SHF_WR: begin
                o_cmd.wr_rdata = 1'b1;
                o_cmd.idx_inc  = 1'b1;
                n_state        = S_SHF_CHK;
            end
            S_RUN_CHK: begin
                n_state = (i_stat.empty || i_stat.exp_full) ? S_HEAD_RD : S_RUN_RD;
            end
            S_RUN_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_HEAD;
                n_state      = S_RUN_CMP;
            end
            S_RUN_CMP: begin
                if (i_stat.expired) begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_RUN_CHK;
                end else begin
                    n_state = S_HEAD_RD;
                end
            end
            S_HEAD_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_HEAD;
                n_state      = S_HEAD_LD;
            end
            S_HEAD_LD: begin
                o_cmd.head_load = 1'b1;
                n_state         = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.emit_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

[rtl/sdcq_dp.sv]
// Datapath of the sorted delayed call queue: entry storage, cursors, id counter and result register.
`timescale 1ns / 1ps

module sdcq_dp #(
    parameter int QUEUE_DEPTH = sdcq_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = sdcq_pkg::ID_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sdcq_pkg::t_cmd  i_cmd,
    output sdcq_pkg::t_stat o_stat,
    input  sdcq_pkg::t_req  i_req_data,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output sdcq_pkg::t_rsp  o_rsp_data
);
    import sdcq_pkg::*;

    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W   = CNT_W + 1;
    localparam int RAM_W   = TIME_W + ID_BITS;
    localparam int CMP_W   = (ID_BITS > TGT_W) ? ID_BITS : TGT_W;
    localparam int EXP_W   = $clog2(MAX_OUT);
    localparam int NEXP_W  = $clog2(MAX_OUT + 1);
    localparam int TSUM_W  = TIME_W + 1;

    // Maps a position counted from the head onto a storage row.
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                              input logic [CNT_W-1:0] pos);
        logic [SUM_W-1:0] s;
        s = SUM_W'(base) + SUM_W'(pos);
        if (s >= SUM_W'(QUEUE_DEPTH)) begin
            s = s - SUM_W'(QUEUE_DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    // Control state.
    logic [IDX_W-1:0]   r_base,  n_base;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [ID_BITS-1:0] r_id_ctr, n_id_ctr;
    logic [CNT_W-1:0]   r_idx,   n_idx;
    logic [NEXP_W-1:0]  r_nexp,  n_nexp;
    logic [NEXP_W-1:0]  r_emit,  n_emit;
    logic               r_out_valid, n_out_valid;

    // Payload state.
    logic [FUNC_W-1:0]   r_func,     n_func;
    logic [TIME_W-1:0]   r_now,      n_now;
    logic [TIME_W-1:0]   r_due_new,  n_due_new;
    logic [TGT_W-1:0]    r_target,   n_target;
    logic [STATUS_W-1:0] r_status,   n_status;
    logic [OUT_ID_W-1:0] r_res_id,   n_res_id;
    logic [TIME_W-1:0]   r_head_due, n_head_due;
    logic [OUT_ID_W-1:0] r_exp_ids [MAX_OUT];
    t_rsp                r_out,      n_out;

    logic [TSUM_W-1:0]  w_due_sum;
    logic [TIME_W-1:0]  w_due_sat;
    logic [CNT_W-1:0]   w_rd_pos;
    logic [IDX_W-1:0]   w_raddr;
    logic [IDX_W-1:0]   w_waddr;
    logic [RAM_W-1:0]   w_wdata;
    logic [RAM_W-1:0]   w_rdata;
    logic [TIME_W-1:0]  w_rd_due;
    logic [ID_BITS-1:0] w_rd_tag;
    logic [ID_BITS-1:0] w_id_inc;
    logic [TIME_W-1:0]  w_head;
    logic               w_empty;
    logic               w_emit_last;
    t_rsp               w_rsp;

    assign w_due_sum = {1'b0, i_req_data.now_time} + TSUM_W'(i_req_data.delay);
    assign w_due_sat = w_due_sum[TIME_W] ? '1 : w_due_sum[TIME_W-1:0];

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_PREV: w_rd_pos = r_idx - CNT_W'(1);
            RD_CUR:  w_rd_pos = r_idx;
            RD_NEXT: w_rd_pos = r_idx + CNT_W'(1);
            RD_HEAD: w_rd_pos = '0;
            default: w_rd_pos = '0;
        endcase
    end

    assign w_raddr  = phys(r_base, w_rd_pos);
    assign w_waddr  = phys(r_base, r_idx);
    assign w_wdata  = i_cmd.wr_new ? {r_due_new, r_id_ctr} : w_rdata;
    assign w_rd_due = w_rdata[RAM_W-1 -: TIME_W];
    assign w_rd_tag = w_rdata[ID_BITS-1:0];

    sdcq_ram #(
        .WIDTH (RAM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_rdata | i_cmd.wr_new),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_empty     = (r_count == '0);
    assign w_emit_last = (r_nexp == '0) || (NEXP_W'(r_emit + NEXP_W'(1)) == r_nexp);
    assign w_id_inc    = r_id_ctr + ID_BITS'(1);

    // Result as it leaves: the head report reflects the queue after the whole operation.
    always_comb begin
        w_head             = w_empty ? '0 : r_head_due;
        w_rsp.status       = r_status;
        w_rsp.head_pending = !w_empty;
        w_rsp.head_time    = w_head;
        w_rsp.next_delay   = (w_head > r_now) ? (w_head - r_now) : '0;
        if (r_nexp != '0) begin
            w_rsp.out_id = r_exp_ids[r_emit[EXP_W-1:0]];
            w_rsp.fired  = 1'b1;
            w_rsp.last   = w_emit_last;
        end else begin
            w_rsp.out_id = r_res_id;
            w_rsp.fired  = 1'b0;
            w_rsp.last   = 1'b1;
        end
    end

    always_comb begin
        o_stat.func      = r_func;
        o_stat.full      = (r_count == CNT_W'(QUEUE_DEPTH));
        o_stat.empty     = w_empty;
        o_stat.idx_zero  = (r_idx == '0);
        o_stat.idx_last  = (CNT_W'(r_idx + CNT_W'(1)) == r_count);
        o_stat.later     = (w_rd_due > r_due_new);
        o_stat.tag_hit   = (CMP_W'(w_rd_tag) == CMP_W'(r_target));
        o_stat.expired   = (w_rd_due <= r_now);
        o_stat.exp_full  = (r_nexp == NEXP_W'(MAX_OUT));
        o_stat.out_free  = !r_out_valid || i_out_ready;
        o_stat.emit_last = w_emit_last;
    end

    always_comb begin
        n_base      = r_base;
        n_count     = r_count;
        n_id_ctr    = r_id_ctr;
        n_idx       = r_idx;
        n_nexp      = r_nexp;
        n_emit      = r_emit;
        n_out_valid = r_out_valid;
        n_func      = r_func;
        n_now       = r_now;
        n_due_new   = r_due_new;
        n_target    = r_target;
        n_status    = r_status;
        n_res_id    = r_res_id;
        n_head_due  = r_head_due;
        n_out       = r_out;

        if (i_cmd.capture) begin
            n_func    = i_req_data.func;
            n_now     = i_req_data.now_time;
            n_due_new = w_due_sat;
            n_target  = i_req_data.target_id;
            n_status  = ST_DONE;
            n_res_id  = '0;
            n_nexp    = '0;
            n_emit    = '0;
            n_idx     = '0;
        end
        if (i_cmd.set_full) begin
            n_status = ST_FULL;
        end
        if (i_cmd.set_notfound) begin
            n_status = ST_NOT_FOUND;
        end
        if (i_cmd.idx_from_count) begin
            n_idx = r_count;
        end
        if (i_cmd.idx_inc) begin
            n_idx = r_idx + CNT_W'(1);
        end
        if (i_cmd.idx_dec) begin
            n_idx = r_idx - CNT_W'(1);
        end
        if (i_cmd.wr_new) begin
            n_count  = r_count + CNT_W'(1);
            n_res_id = OUT_ID_W'(r_id_ctr);
            n_id_ctr = (w_id_inc == '0) ? ID_BITS'(1) : w_id_inc;
        end
        if (i_cmd.cnt_dec) begin
            n_count = r_count - CNT_W'(1);
        end
        if (i_cmd.pop) begin
            n_count = r_count - CNT_W'(1);
            n_base  = phys(r_base, CNT_W'(1));
            n_nexp  = r_nexp + NEXP_W'(1);
        end
        if (i_cmd.head_load) begin
            n_head_due = w_rd_due;
        end
        if (i_cmd.emit) begin
            n_emit      = r_emit + NEXP_W'(1);
            n_out_valid = 1'b1;
            n_out       = w_rsp;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_count     <= '0;
            r_id_ctr    <= ID_BITS'(1);
            r_idx       <= '0;
            r_nexp      <= '0;
            r_emit      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_base      <= n_base;
            r_count     <= n_count;
            r_id_ctr    <= n_id_ctr;
            r_idx       <= n_idx;
            r_nexp      <= n_nexp;
            r_emit      <= n_emit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_now      <= n_now;
        r_due_new  <= n_due_new;
        r_target   <= n_target;
        r_status   <= n_status;
        r_res_id   <= n_res_id;
        r_head_due <= n_head_due;
        r_out      <= n_out;
        if (i_cmd.pop) begin
            r_exp_ids[r_nexp[EXP_W-1:0]] <= OUT_ID_W'(w_rd_tag);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_rsp_data  = r_out;
endmodule

[rtl/sdcq_checker.sv]
// Port-level checks on the result channel of the sorted delayed call queue, bound to the top level.
`timescale 1ns / 1ps

module sdcq_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_rsp_valid,
    input logic           i_rsp_ready,
    input sdcq_pkg::t_rsp i_rsp
);
    import sdcq_pkg::*;

    // A stalled result stays offered and unchanged.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp))
        else $error("result changed or dropped while stalled");

    // Only a run burst has results before the last one, and each carries an expired id.
    a_burst_fired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp.last |-> i_rsp.fired && (i_rsp.status == ST_DONE))
        else $error("non-final result without an expired entry");

    // A refused schedule or a failed cancel is a lone result with no id.
    a_error_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp.status != ST_DONE)
        |-> i_rsp.last && !i_rsp.fired && (i_rsp.out_id == '0))
        else $error("error result carries an id or is not final");

    // An empty queue reports a zero head time and delay.
    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp.head_pending
        |-> (i_rsp.head_time == '0) && (i_rsp.next_delay == '0))
        else $error("empty queue with nonzero head report");

    // The remaining delay never exceeds the head due time.
    a_delay_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_rsp.next_delay <= i_rsp.head_time)
        else $error("remaining delay beyond the head due time");
endmodule

bind sorted_delayed_call_queue_unit sdcq_checker u_sdcq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp       (o_rsp.payload)
);
